// ===== design/i2cms_pkg.sv =====
// Package: shared types, status codes, control masks and register map of the I2C status sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int BUF_DEPTH_DEF = 32;

    // register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_XFER_LEN   = 2'd1;
    localparam logic [1:0] REG_NOTIFY_EN  = 2'd2;

    // request types
    localparam logic [1:0] REQ_STATUS = 2'd0;
    localparam logic [1:0] REQ_BUF_WR = 2'd1;
    localparam logic [1:0] REQ_BUF_RD = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // controller status codes
    localparam logic [7:0] ST_BUS_ERR    = 8'd0;
    localparam logic [7:0] ST_START      = 8'd8;
    localparam logic [7:0] ST_RSTART     = 8'd16;
    localparam logic [7:0] ST_SLA_W_ACK  = 8'd24;
    localparam logic [7:0] ST_SLA_W_NACK = 8'd32;
    localparam logic [7:0] ST_TX_ACK     = 8'd40;
    localparam logic [7:0] ST_TX_NACK    = 8'd48;
    localparam logic [7:0] ST_ARB_LOST   = 8'd56;
    localparam logic [7:0] ST_SLA_R_ACK  = 8'd64;
    localparam logic [7:0] ST_SLA_R_NACK = 8'd72;
    localparam logic [7:0] ST_RX_ACK     = 8'd80;
    localparam logic [7:0] ST_RX_NACK    = 8'd88;

    // control register masks
    localparam logic [7:0] MSK_50 = 8'h50;
    localparam logic [7:0] MSK_28 = 8'h28;
    localparam logic [7:0] MSK_40 = 8'h40;
    localparam logic [7:0] MSK_18 = 8'h18;
    localparam logic [7:0] MSK_38 = 8'h38;
    localparam logic [7:0] MSK_60 = 8'h60;
    localparam logic [7:0] MSK_44 = 8'h44;
    localparam logic [7:0] MSK_1C = 8'h1C;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [4:0] buf_index;
        logic [7:0] buf_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] set_bits;
        logic [7:0] clear_bits;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       notify;
        logic [7:0] notify_code;
        logic       data_good;
        logic [7:0] read_byte;
        logic       overrun;
    } out_item_t;

endpackage

// ===== design/i2cms_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/i2c_master_status_sequencer_top.sv =====
// An accepted item is registered in stage 1, then in the output register, which drives m_valid.
// Throughput: one item per cycle unless m_ready stalls the output; the buffer RAM is written
// and read at the accept edge, so a back-to-back item reads the entry that the item before it wrote.
// A stalled result is held in the output register while one more item waits in stage 1.
// Reset (aresetn low, synchronous) clears position, running sum, good flag, slave address,
// notify enable and all valids and sets the length to 1; buffer contents stay undefined until written.
`timescale 1ns / 1ps

module i2c_master_status_sequencer_top #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  i2cms_pkg::in_item_t            s_payload,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output i2cms_pkg::out_item_t           m_payload,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cms_pkg::PADDR_W-1:0]  paddr,
    input  logic [i2cms_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cms_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int POS_W  = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W  = (POS_W > 6) ? POS_W : 6;

    // ---------------- configuration ----------------
    logic [7:0] slave_addr_reg;
    logic [5:0] xfer_len_reg;
    logic       notify_en_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= 8'd0;
            xfer_len_reg   <= 6'd1;
            notify_en_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                i2cms_pkg::REG_SLAVE_ADDR: slave_addr_reg <= pwdata[7:0];
                i2cms_pkg::REG_XFER_LEN:   xfer_len_reg   <= pwdata[5:0];
                i2cms_pkg::REG_NOTIFY_EN:  notify_en_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            i2cms_pkg::REG_SLAVE_ADDR: prdata[7:0] = slave_addr_reg;
            i2cms_pkg::REG_XFER_LEN:   prdata[5:0] = xfer_len_reg;
            i2cms_pkg::REG_NOTIFY_EN:  prdata[0]   = notify_en_reg;
            default: prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic      p1_valid_reg, p1_valid_next;
    logic      m_valid_reg, m_valid_next;
    logic      p1_move;
    logic      s_accept;

    assign p1_move       = p1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready       = ~p1_valid_reg | p1_move;
    assign s_accept      = s_valid & s_ready;
    assign p1_valid_next = s_accept | (p1_valid_reg & ~p1_move);
    assign m_valid_next  = p1_move | (m_valid_reg & ~m_ready);
    assign m_valid       = m_valid_reg;

    // ---------------- stage 0: decode and state update ----------------
    logic [POS_W-1:0]  pos_reg, pos_next, pos_inc;
    logic [7:0]        sum_reg, sum_next;
    logic              good_reg, good_next;
    logic [CMP_W-1:0]  pos_ext, len_ext, idx_ext, depth_ext;
    logic              pos_full, idx_ok, take_last, pos_eq_len, pos_after_eq;
    logic              do_take, do_give, tx_ram, rd_ram;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    i2cms_pkg::out_item_t res0;

    assign pos_inc      = pos_reg + POS_W'(1);
    assign pos_ext      = CMP_W'(pos_reg);
    assign len_ext      = CMP_W'(xfer_len_reg);
    assign idx_ext      = CMP_W'(s_payload.buf_index);
    assign depth_ext    = CMP_W'(BUF_DEPTH);
    assign pos_full     = (pos_ext >= depth_ext);
    assign idx_ok       = (idx_ext < depth_ext);
    assign take_last    = (CMP_W'(pos_inc) == len_ext);
    assign pos_eq_len   = (pos_ext == len_ext);
    // position compared with length after the store (store skipped when full)
    assign pos_after_eq = pos_full ? pos_eq_len : take_last;

    always_comb begin
        res0      = '0;
        do_take   = 1'b0;
        do_give   = 1'b0;
        tx_ram    = 1'b0;
        rd_ram    = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = pos_reg[ADDR_W-1:0];
        ram_raddr = pos_reg[ADDR_W-1:0];
        ram_wdata = s_payload.rx_byte;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        good_next = good_reg;

        case (s_payload.req_type)
            i2cms_pkg::REQ_STATUS: begin
                case (s_payload.status_code)
                    i2cms_pkg::ST_BUS_ERR: begin
                        res0.set_bits   = i2cms_pkg::MSK_50;
                        res0.clear_bits = i2cms_pkg::MSK_28;
                    end
                    i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
                        res0.tx_valid   = 1'b1;
                        res0.tx_byte    = slave_addr_reg;
                        res0.set_bits   = i2cms_pkg::MSK_40;
                        res0.clear_bits = i2cms_pkg::MSK_18;
                    end
                    i2cms_pkg::ST_SLA_W_ACK: begin
                        do_give         = 1'b1;
                        res0.set_bits   = i2cms_pkg::MSK_40;
                        res0.clear_bits = i2cms_pkg::MSK_38;
                    end
                    i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_TX_NACK,
                    i2cms_pkg::ST_SLA_R_NACK: begin
                        res0.notify     = 1'b1;
                        res0.set_bits   = i2cms_pkg::MSK_50;
                        res0.clear_bits = i2cms_pkg::MSK_28;
                    end
                    i2cms_pkg::ST_TX_ACK: begin
                        if (pos_eq_len) begin
                            res0.notify     = 1'b1;
                            res0.set_bits   = i2cms_pkg::MSK_50;
                            res0.clear_bits = i2cms_pkg::MSK_28;
                        end else begin
                            do_give         = 1'b1;
                            res0.set_bits   = i2cms_pkg::MSK_40;
                            res0.clear_bits = i2cms_pkg::MSK_38;
                        end
                    end
                    i2cms_pkg::ST_ARB_LOST: begin
                        res0.set_bits   = i2cms_pkg::MSK_60;
                        res0.clear_bits = i2cms_pkg::MSK_18;
                    end
                    i2cms_pkg::ST_SLA_R_ACK: begin
                        res0.set_bits   = i2cms_pkg::MSK_44;
                        res0.clear_bits = i2cms_pkg::MSK_38;
                    end
                    i2cms_pkg::ST_RX_ACK: begin
                        do_take = 1'b1;
                        if (pos_after_eq) begin
                            res0.set_bits   = i2cms_pkg::MSK_40;
                            res0.clear_bits = i2cms_pkg::MSK_1C;
                        end else begin
                            res0.set_bits   = i2cms_pkg::MSK_44;
                            res0.clear_bits = i2cms_pkg::MSK_18;
                        end
                    end
                    i2cms_pkg::ST_RX_NACK: begin
                        do_take         = 1'b1;
                        res0.notify     = 1'b1;
                        res0.set_bits   = i2cms_pkg::MSK_50;
                        res0.clear_bits = i2cms_pkg::MSK_28;
                    end
                    default: ;
                endcase
                res0.notify = res0.notify & notify_en_reg;
                if (res0.notify) begin
                    res0.notify_code = s_payload.status_code;
                end
            end
            i2cms_pkg::REQ_BUF_WR: begin
                if (idx_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_ext[ADDR_W-1:0];
                    ram_wdata = s_payload.buf_data;
                end else begin
                    res0.overrun = 1'b1;
                end
            end
            i2cms_pkg::REQ_BUF_RD: begin
                if (idx_ok) begin
                    ram_re    = 1'b1;
                    rd_ram    = 1'b1;
                    ram_raddr = idx_ext[ADDR_W-1:0];
                end else begin
                    res0.overrun = 1'b1;
                end
            end
            default: begin
                pos_next  = '0;
                sum_next  = 8'd0;
                good_next = 1'b0;
            end
        endcase

        // fetch next transmit byte at the running position
        if (do_give) begin
            if (pos_full) begin
                res0.overrun = 1'b1;
            end else begin
                ram_re   = 1'b1;
                tx_ram   = 1'b1;
                pos_next = pos_inc;
            end
        end

        // store received byte; last byte of the transfer is the checksum
        if (do_take) begin
            if (pos_full) begin
                res0.overrun = 1'b1;
            end else begin
                ram_we   = 1'b1;
                pos_next = pos_inc;
                if (take_last) begin
                    if (sum_reg == s_payload.rx_byte) begin
                        good_next = 1'b1;
                    end
                end else begin
                    sum_next = sum_reg + s_payload.rx_byte;
                end
            end
        end

        res0.data_good = good_next;
        res0.tx_valid  = res0.tx_valid | tx_ram;
    end

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .aclk  (aclk),
        .we    (ram_we & s_accept),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re & s_accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1 and output register ----------------
    i2cms_pkg::out_item_t p1_item_reg;
    i2cms_pkg::out_item_t m_payload_reg;
    i2cms_pkg::out_item_t m_payload_next;
    logic                 p1_tx_ram_reg;
    logic                 p1_rd_ram_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= 8'd0;
            good_reg     <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s_accept) begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                good_reg <= good_next;
            end
        end
    end

    // RAM read data holds while stage 1 stalls, since no new read is issued
    always_comb begin
        m_payload_next = p1_item_reg;
        if (p1_tx_ram_reg) begin
            m_payload_next.tx_byte = ram_rdata;
        end
        if (p1_rd_ram_reg) begin
            m_payload_next.read_byte = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_item_reg   <= res0;
            p1_tx_ram_reg <= tx_ram;
            p1_rd_ram_reg <= rd_ram;
        end
        if (p1_move) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_payload = m_payload_reg;

    // ---------------- assertions ----------------
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(BUF_DEPTH))
        else $error("position past buffer depth");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_payload.req_type == i2cms_pkg::REQ_CLEAR)
        |=> (pos_reg == '0 && sum_reg == 8'd0 && !good_reg))
        else $error("clear item left position, sum or flag set");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && pos_full && s_payload.req_type == i2cms_pkg::REQ_STATUS)
        |=> $stable(pos_reg))
        else $error("position moved while at depth");

    a_ram_one_use: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !(ram_we && ram_re))
        else $error("one item both wrote and read the buffer");

endmodule

// ===== tb/i2c_master_status_sequencer_top_test.sv =====
// Testbench for the I2C master status sequencer: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module i2c_master_status_sequencer_top_test;

    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DEPTH          = i2cms_pkg::BUF_DEPTH_DEF;
    localparam int IN_W           = $bits(i2cms_pkg::in_item_t);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    i2cms_pkg::in_item_t  s_payload = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    i2cms_pkg::out_item_t m_payload;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [i2cms_pkg::PADDR_W-1:0] paddr = '0;
    logic [i2cms_pkg::PDATA_W-1:0] pwdata = '0;
    logic [i2cms_pkg::PDATA_W-1:0] prdata;
    logic                          pready;

    i2c_master_status_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // items waiting to be offered, and responses predicted for accepted items
    i2cms_pkg::in_item_t  pending_items[$];
    i2cms_pkg::out_item_t expected_responses[$];

    // predictor state
    logic [7:0] shadow_store [DEPTH];
    int         xfer_pos = 0;
    logic [7:0] rx_sum = 8'd0;
    logic       data_ok = 1'b0;
    logic [7:0] cfg_slave_addr = 8'd0;
    logic [5:0] cfg_xfer_len = 6'd1;
    logic       cfg_notify_en = 1'b0;

    int   cycle_count = 0;
    int   fail_count = 0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   rx_draw;
    int   rx_hold_left = 0;
    logic rx_hold_arm = 1'b0;
    logic rx_hold_taken = 1'b0;
    logic tx_calm;
    logic rx_calm;

    assign tx_calm = (cycle_count % 900) < 150;
    assign rx_calm = (cycle_count % 700) < 120;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void take_rx_byte(input logic [7:0] b,
                                         inout i2cms_pkg::out_item_t r);
        if (xfer_pos >= DEPTH) begin
            r.overrun = 1'b1;
            return;
        end
        shadow_store[xfer_pos] = b;
        xfer_pos++;
        // last byte of the transfer is the checksum
        if (xfer_pos == cfg_xfer_len) begin
            if (rx_sum == b)
                data_ok = 1'b1;
        end else begin
            rx_sum = rx_sum + b;
        end
    endfunction

    function automatic void fetch_tx_byte(inout i2cms_pkg::out_item_t r);
        if (xfer_pos >= DEPTH) begin
            r.overrun = 1'b1;
            return;
        end
        r.tx_valid = 1'b1;
        r.tx_byte = shadow_store[xfer_pos];
        xfer_pos++;
    endfunction

    function automatic i2cms_pkg::out_item_t handler_response(input i2cms_pkg::in_item_t it);
        i2cms_pkg::out_item_t r;
        logic                 ntf;
        r = '0;
        ntf = 1'b0;
        case (it.req_type)
            i2cms_pkg::REQ_STATUS: begin
                case (it.status_code)
                    i2cms_pkg::ST_BUS_ERR: begin
                        r.set_bits = i2cms_pkg::MSK_50;
                        r.clear_bits = i2cms_pkg::MSK_28;
                    end
                    i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = cfg_slave_addr;
                        r.set_bits = i2cms_pkg::MSK_40;
                        r.clear_bits = i2cms_pkg::MSK_18;
                    end
                    i2cms_pkg::ST_SLA_W_ACK: begin
                        fetch_tx_byte(r);
                        r.set_bits = i2cms_pkg::MSK_40;
                        r.clear_bits = i2cms_pkg::MSK_38;
                    end
                    i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_TX_NACK,
                    i2cms_pkg::ST_SLA_R_NACK: begin
                        ntf = 1'b1;
                        r.set_bits = i2cms_pkg::MSK_50;
                        r.clear_bits = i2cms_pkg::MSK_28;
                    end
                    i2cms_pkg::ST_TX_ACK: begin
                        if (xfer_pos == cfg_xfer_len) begin
                            ntf = 1'b1;
                            r.set_bits = i2cms_pkg::MSK_50;
                            r.clear_bits = i2cms_pkg::MSK_28;
                        end else begin
                            fetch_tx_byte(r);
                            r.set_bits = i2cms_pkg::MSK_40;
                            r.clear_bits = i2cms_pkg::MSK_38;
                        end
                    end
                    i2cms_pkg::ST_ARB_LOST: begin
                        r.set_bits = i2cms_pkg::MSK_60;
                        r.clear_bits = i2cms_pkg::MSK_18;
                    end
                    i2cms_pkg::ST_SLA_R_ACK: begin
                        r.set_bits = i2cms_pkg::MSK_44;
                        r.clear_bits = i2cms_pkg::MSK_38;
                    end
                    i2cms_pkg::ST_RX_ACK: begin
                        take_rx_byte(it.rx_byte, r);
                        if (xfer_pos == cfg_xfer_len) begin
                            r.set_bits = i2cms_pkg::MSK_40;
                            r.clear_bits = i2cms_pkg::MSK_1C;
                        end else begin
                            r.set_bits = i2cms_pkg::MSK_44;
                            r.clear_bits = i2cms_pkg::MSK_18;
                        end
                    end
                    i2cms_pkg::ST_RX_NACK: begin
                        take_rx_byte(it.rx_byte, r);
                        ntf = 1'b1;
                        r.set_bits = i2cms_pkg::MSK_50;
                        r.clear_bits = i2cms_pkg::MSK_28;
                    end
                    default: ;
                endcase
                if (ntf && cfg_notify_en) begin
                    r.notify = 1'b1;
                    r.notify_code = it.status_code;
                end
            end
            i2cms_pkg::REQ_BUF_WR: shadow_store[it.buf_index] = it.buf_data;
            i2cms_pkg::REQ_BUF_RD: r.read_byte = shadow_store[it.buf_index];
            default: begin
                xfer_pos = 0;
                rx_sum = 8'd0;
                data_ok = 1'b0;
            end
        endcase
        r.data_good = data_ok;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_response(input i2cms_pkg::out_item_t got);
        i2cms_pkg::out_item_t want;
        if (expected_responses.size() == 0) begin
            $error("result 0x%h arrived with no item outstanding", got);
            fail_count++;
            return;
        end
        want = expected_responses.pop_front();
        compare_field("set_bits", want.set_bits, got.set_bits);
        compare_field("clear_bits", want.clear_bits, got.clear_bits);
        compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("notify", 8'(want.notify), 8'(got.notify));
        compare_field("notify_code", want.notify_code, got.notify_code);
        compare_field("data_good", 8'(want.data_good), 8'(got.data_good));
        compare_field("read_byte", want.read_byte, got.read_byte);
        compare_field("overrun", 8'(want.overrun), 8'(got.overrun));
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_responses.push_back(handler_response(s_payload));
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    s_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_payload <= pending_items.pop_front();
                    tx_gap <= tx_calm ? 0 : $urandom_range(0, 3);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
            rx_hold_left <= 0;
            rx_hold_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_response(m_payload);
            if (rx_hold_arm && !rx_hold_taken) begin
                // long back-pressure: let the block fill up and stall its input
                rx_hold_taken <= 1'b1;
                rx_hold_left <= RX_HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (rx_hold_left != 0) begin
                rx_hold_left <= rx_hold_left - 1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                rx_draw = rx_calm ? 0 : $urandom_range(0, 3);
                rx_wait <= rx_draw;
                m_ready <= (rx_draw == 0);
            end else if (rx_wait > 1) begin
                rx_wait <= rx_wait - 1;
                m_ready <= 1'b0;
            end else begin
                rx_wait <= 0;
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_responses.size() != 0);
    endtask

    task automatic write_register(input logic [1:0] reg_idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            i2cms_pkg::REG_SLAVE_ADDR: cfg_slave_addr = value[7:0];
            i2cms_pkg::REG_XFER_LEN:   cfg_xfer_len = value[5:0];
            default:                   cfg_notify_en = value[0];
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] addr, input logic [5:0] len,
                                 input logic ntf_en);
        wait_drained();
        write_register(i2cms_pkg::REG_SLAVE_ADDR, {24'd0, addr});
        write_register(i2cms_pkg::REG_XFER_LEN, {26'd0, len});
        write_register(i2cms_pkg::REG_NOTIFY_EN, {31'd0, ntf_en});
    endtask

    function automatic void queue_status(input logic [7:0] code, input logic [7:0] rx);
        i2cms_pkg::in_item_t it;
        it = IN_W'($urandom);
        it.req_type = i2cms_pkg::REQ_STATUS;
        it.status_code = code;
        it.rx_byte = rx;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_request(input logic [1:0] req, input logic [4:0] idx,
                                          input logic [7:0] data);
        i2cms_pkg::in_item_t it;
        it = IN_W'($urandom);
        it.req_type = req;
        it.buf_index = idx;
        it.buf_data = data;
        pending_items.push_back(it);
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 11))
            0:       return i2cms_pkg::ST_BUS_ERR;
            1:       return i2cms_pkg::ST_START;
            2:       return i2cms_pkg::ST_RSTART;
            3:       return i2cms_pkg::ST_SLA_W_ACK;
            4:       return i2cms_pkg::ST_SLA_W_NACK;
            5:       return i2cms_pkg::ST_TX_ACK;
            6:       return i2cms_pkg::ST_TX_NACK;
            7:       return i2cms_pkg::ST_ARB_LOST;
            8:       return i2cms_pkg::ST_SLA_R_ACK;
            9:       return i2cms_pkg::ST_SLA_R_NACK;
            10:      return i2cms_pkg::ST_RX_ACK;
            default: return i2cms_pkg::ST_RX_NACK;
        endcase
    endfunction

    function automatic logic [7:0] pick_advance_code();
        case ($urandom_range(0, 3))
            0:       return i2cms_pkg::ST_SLA_W_ACK;
            1:       return i2cms_pkg::ST_TX_ACK;
            2:       return i2cms_pkg::ST_RX_ACK;
            default: return i2cms_pkg::ST_RX_NACK;
        endcase
    endfunction

    function automatic void queue_traffic(input int count);
        int                  target;
        int                  len;
        int                  kind;
        logic [7:0]          sum;
        logic [7:0]          b;
        i2cms_pkg::in_item_t it;
        target = pending_items.size() + count;
        while (pending_items.size() < target) begin
            kind = $urandom_range(0, 99);
            len = (cfg_xfer_len >= 1 && cfg_xfer_len <= DEPTH) ?
                  int'(cfg_xfer_len) : $urandom_range(1, 6);
            if (kind < 40) begin
                // read transfer ending in a checksum byte, usually a matching one
                queue_request(i2cms_pkg::REQ_CLEAR, 5'($urandom), 8'($urandom));
                queue_status(i2cms_pkg::ST_START, 8'($urandom));
                queue_status(i2cms_pkg::ST_SLA_R_ACK, 8'($urandom));
                sum = 8'd0;
                for (int i = 0; i < len - 1; i++) begin
                    b = 8'($urandom);
                    sum = sum + b;
                    queue_status(i2cms_pkg::ST_RX_ACK, b);
                end
                b = ($urandom_range(0, 3) != 0) ? sum : 8'($urandom);
                queue_status($urandom_range(0, 1) ? i2cms_pkg::ST_RX_NACK
                                                  : i2cms_pkg::ST_RX_ACK, b);
            end else if (kind < 65) begin
                // write transfer: refresh a few entries, then send until done or nack
                repeat ($urandom_range(0, 3))
                    queue_request(i2cms_pkg::REQ_BUF_WR, 5'($urandom), 8'($urandom));
                queue_request(i2cms_pkg::REQ_CLEAR, 5'($urandom), 8'($urandom));
                queue_status($urandom_range(0, 1) ? i2cms_pkg::ST_START
                                                  : i2cms_pkg::ST_RSTART, 8'($urandom));
                queue_status(i2cms_pkg::ST_SLA_W_ACK, 8'($urandom));
                repeat ($urandom_range(0, len + 1))
                    queue_status(i2cms_pkg::ST_TX_ACK, 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    queue_status(i2cms_pkg::ST_TX_NACK, 8'($urandom));
            end else if (kind < 73) begin
                // offer more advancing items than the buffer depth, so the position can reach the depth
                queue_request(i2cms_pkg::REQ_CLEAR, 5'($urandom), 8'($urandom));
                repeat ($urandom_range(33, 38))
                    queue_status(pick_advance_code(), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    it = IN_W'($urandom);
                    if ($urandom_range(0, 1))
                        it.status_code = pick_code();
                    pending_items.push_back(it);
                end
            end
        end
    endfunction

    function automatic void queue_directed();
        // fill every entry so that no fetch or read ever sees an unwritten one
        queue_request(i2cms_pkg::REQ_BUF_WR, 5'd0, 8'h00);
        for (int i = 1; i < DEPTH - 1; i++)
            queue_request(i2cms_pkg::REQ_BUF_WR, 5'(i), 8'($urandom));
        queue_request(i2cms_pkg::REQ_BUF_WR, 5'd31, 8'hFF);

        queue_request(i2cms_pkg::REQ_BUF_RD, 5'd0, 8'($urandom));
        queue_request(i2cms_pkg::REQ_BUF_RD, 5'd31, 8'($urandom));
        queue_request(i2cms_pkg::REQ_CLEAR, 5'($urandom), 8'($urandom));
        queue_status(i2cms_pkg::ST_BUS_ERR, 8'($urandom));
        queue_status(i2cms_pkg::ST_START, 8'($urandom));
        queue_status(i2cms_pkg::ST_RSTART, 8'($urandom));
        queue_status(i2cms_pkg::ST_SLA_W_ACK, 8'($urandom));
        queue_status(i2cms_pkg::ST_SLA_W_NACK, 8'($urandom));
        queue_status(i2cms_pkg::ST_TX_ACK, 8'($urandom));
        queue_status(i2cms_pkg::ST_TX_NACK, 8'($urandom));
        queue_status(i2cms_pkg::ST_ARB_LOST, 8'($urandom));
        queue_status(i2cms_pkg::ST_SLA_R_ACK, 8'($urandom));
        queue_status(i2cms_pkg::ST_SLA_R_NACK, 8'($urandom));
        // third byte with a length of three: a zero checksum matches the empty sum
        queue_status(i2cms_pkg::ST_RX_ACK, 8'h00);
        queue_status(i2cms_pkg::ST_RX_NACK, 8'hFF);
        queue_status(8'hFF, 8'($urandom));
        queue_status(8'h01, 8'($urandom));
        queue_status(8'h60, 8'($urandom));
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        apply_setting(8'hA5, 6'd3, 1'b1);
        queue_directed();

        apply_setting(8'h00, 6'd1, 1'b0);
        queue_traffic(200);

        apply_setting(8'hFF, 6'd32, 1'b1);
        queue_traffic(200);
        rx_hold_arm <= 1'b1;

        apply_setting(8'($urandom), 6'd0, 1'b1);
        queue_traffic(100);
        // hold the sender until every result is back, then resume
        wait_drained();
        queue_traffic(100);

        apply_setting(8'($urandom), 6'd63, 1'b0);
        queue_traffic(200);

        apply_setting(8'($urandom), 6'($urandom_range(2, 12)), 1'b1);
        queue_traffic(200);

        apply_setting(8'($urandom), 6'($urandom_range(1, 8)), 1'($urandom));
        queue_traffic(100);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
